/* hw/rtl/heap_sort_engine_macros.svh */
// Assertion macros for the heap sort engine.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// Generic clocked check, disabled while reset is asserted.
`define HSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
  `HSE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* hw/rtl/hse_pkg.sv */
// Shared types and constants of the heap sort engine.
// No dependencies; used by heap_sort_engine and the testbench.
package hse_pkg;

  localparam int DATA_W            = 32;
  localparam int MAX_ITEMS_DEFAULT = 64;

  // One input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] value_in;
    logic                     last_in;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD_NEXT,
    ST_SIFT_LOAD,
    ST_SIFT_HOLD,
    ST_SIFT_READ,
    ST_SIFT_CMP,
    ST_SIFT_FIN,
    ST_EXTRACT_NEXT,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

endpackage

/* hw/rtl/hse_ram.sv */
// Element store: one write port, two registered read ports.
// Depends on nothing; instantiated by heap_sort_engine.
module hse_ram #(
  parameter int DATA_W = 32,
  parameter int AW     = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write, and read with write-first forwarding on an address match
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

endmodule

/* hw/rtl/heap_sort_engine.sv */
// Heap sort engine. A set of signed 32-bit values arrives one transaction per
// cycle (in_ready is high while the block loads); the transaction marked last
// closes the set, up to MAX_ITEMS values are kept and the rest are dropped,
// which sets overflow on every result of that set. The set is then heapsorted
// in place in a single-write-port store: each sift-down level reads both
// children, then compares and moves the larger one up; every sift also has a
// node step, a root read or a swap read and write, and a final write. Results
// then stream out of the store, smallest first, each held while the result
// channel stalls. Sort time is set by the sift loop through the store's one
// write port, and in_ready stays low until the set has been streamed out.
// A new set may be loaded while the final result of the previous set still
// waits in the output register.
// Depends on hse_pkg, hse_ram and heap_sort_engine_macros.svh.
`include "heap_sort_engine_macros.svh"

module heap_sort_engine #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hse_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hse_pkg::out_item_t out_data
);

  localparam int DW = hse_pkg::DATA_W;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // Control registers
  hse_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            drop_r, drop_nxt;
  logic            extract_r, extract_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [AW-1:0]     top_r, top_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     sift_end_r, sift_end_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [DW-1:0]     held_r, held_nxt;
  hse_pkg::out_item_t out_r, out_nxt;

  // Store ports
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [DW-1:0] wdata, rdata_a, rdata_b;

  hse_ram #(.DATA_W(DW), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Heap index arithmetic
  logic [AW:0]   child, right, cidx, gchild;
  logic [AW:0]   end_ext;
  logic          take_right;
  logic [DW-1:0] cval;
  logic          room, in_fire, out_fire, k_last;
  logic [CW-1:0] cnt_inc;

  assign child      = {node_r, 1'b1};
  assign right      = child + (AW+1)'(1);
  assign end_ext    = {1'b0, sift_end_r};
  assign take_right = (child < end_ext) && ($signed(rdata_a) < $signed(rdata_b));
  assign cidx       = take_right ? right : child;
  assign cval       = take_right ? rdata_b : rdata_a;
  assign gchild     = {cidx[AW-1:0], 1'b1};

  assign room     = cnt_r < CW'(MAX_ITEMS);
  assign in_ready = (state_r == hse_pkg::ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign cnt_inc  = room ? cnt_r + CW'(1) : cnt_r;
  assign k_last   = (k_r == AW'(cnt_r - CW'(1)));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state, store access and output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    extract_nxt   = extract_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    top_nxt       = top_r;
    end_nxt       = end_r;
    sift_end_nxt  = sift_end_r;
    node_nxt      = node_r;
    k_nxt         = k_r;
    held_nxt      = held_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = node_r;
    wdata         = held_r;
    raddr_a       = node_r;
    raddr_b       = node_r;

    case (state_r)
      // Collect the set
      hse_pkg::ST_LOAD: begin
        if (in_fire) begin
          we       = room;
          waddr    = cnt_r[AW-1:0];
          wdata    = in_data.value_in;
          cnt_nxt  = cnt_inc;
          drop_nxt = drop_r | ~room;
          if (in_data.last_in) begin
            extract_nxt = 1'b0;
            k_nxt       = '0;
            top_nxt     = AW'(cnt_inc >> 1);
            state_nxt   = (cnt_inc >= CW'(2)) ? hse_pkg::ST_BUILD_NEXT : hse_pkg::ST_OUT_RD;
          end
        end
      end

      // Heap build: sift every inner node, last one first
      hse_pkg::ST_BUILD_NEXT: begin
        if (top_r == '0) begin
          extract_nxt = 1'b1;
          end_nxt     = AW'(cnt_r - CW'(1));
          state_nxt   = hse_pkg::ST_SWAP_RD;
        end else begin
          top_nxt      = top_r - AW'(1);
          node_nxt     = top_r - AW'(1);
          sift_end_nxt = AW'(cnt_r - CW'(1));
          state_nxt    = hse_pkg::ST_SIFT_LOAD;
        end
      end

      hse_pkg::ST_SIFT_LOAD: begin
        raddr_a   = node_r;
        state_nxt = hse_pkg::ST_SIFT_HOLD;
      end

      // Hold the node's value; at a leaf node nothing moves
      hse_pkg::ST_SIFT_HOLD: begin
        held_nxt = rdata_a;
        if (child > end_ext) begin
          state_nxt = extract_r ? hse_pkg::ST_EXTRACT_NEXT : hse_pkg::ST_BUILD_NEXT;
        end else begin
          state_nxt = hse_pkg::ST_SIFT_READ;
        end
      end

      hse_pkg::ST_SIFT_READ: begin
        raddr_a   = child[AW-1:0];
        raddr_b   = right[AW-1:0];
        state_nxt = hse_pkg::ST_SIFT_CMP;
      end

      // Pick the larger child; move it up unless the held value is larger
      hse_pkg::ST_SIFT_CMP: begin
        if ($signed(cval) < $signed(held_r)) begin
          state_nxt = hse_pkg::ST_SIFT_FIN;
        end else begin
          we        = 1'b1;
          waddr     = node_r;
          wdata     = cval;
          node_nxt  = cidx[AW-1:0];
          state_nxt = (gchild > end_ext) ? hse_pkg::ST_SIFT_FIN : hse_pkg::ST_SIFT_READ;
        end
      end

      hse_pkg::ST_SIFT_FIN: begin
        we        = 1'b1;
        waddr     = node_r;
        wdata     = held_r;
        state_nxt = extract_r ? hse_pkg::ST_EXTRACT_NEXT : hse_pkg::ST_BUILD_NEXT;
      end

      hse_pkg::ST_EXTRACT_NEXT: begin
        if (end_r == AW'(1)) begin
          state_nxt = hse_pkg::ST_OUT_RD;
        end else begin
          end_nxt   = end_r - AW'(1);
          state_nxt = hse_pkg::ST_SWAP_RD;
        end
      end

      // Swap root with the last heap entry
      hse_pkg::ST_SWAP_RD: begin
        raddr_a   = '0;
        raddr_b   = end_r;
        state_nxt = hse_pkg::ST_SWAP_WR;
      end

      // Old root goes to the tail; old tail is sifted down from the root
      hse_pkg::ST_SWAP_WR: begin
        we           = 1'b1;
        waddr        = end_r;
        wdata        = rdata_a;
        held_nxt     = rdata_b;
        node_nxt     = '0;
        sift_end_nxt = end_r - AW'(1);
        state_nxt    = (end_r == AW'(1)) ? hse_pkg::ST_SIFT_FIN : hse_pkg::ST_SIFT_READ;
      end

      // Stream results once the output register frees up
      hse_pkg::ST_OUT_RD: begin
        raddr_a = k_r;
        if (!out_valid_r || out_ready) begin
          state_nxt = hse_pkg::ST_OUT_LD;
        end
      end

      hse_pkg::ST_OUT_LD: begin
        out_valid_nxt     = 1'b1;
        out_nxt.value_out = rdata_a;
        out_nxt.last_out  = k_last;
        out_nxt.overflow  = drop_r;
        if (k_last) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = hse_pkg::ST_LOAD;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = hse_pkg::ST_OUT_RD;
        end
      end

      default: begin
        state_nxt = hse_pkg::ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hse_pkg::ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      extract_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      extract_r   <= extract_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    end_r      <= end_nxt;
    sift_end_r <= sift_end_nxt;
    node_r     <= node_nxt;
    k_r        <= k_nxt;
    held_r     <= held_nxt;
    out_r      <= out_nxt;
  end

  // Checks
  `HSE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_ITEMS), "element count above capacity")
  `HSE_ASSERT_IMP(a_cmp_inner, state_r == hse_pkg::ST_SIFT_CMP, node_r < sift_end_r,
                  "sift compare on a node without children")
  `HSE_ASSERT_IMP(a_swap_end, state_r == hse_pkg::ST_SWAP_RD, end_r != '0,
                  "swap with the root itself")
  `HSE_ASSERT_IMP(a_out_load, $rose(out_valid_r), $past(state_r == hse_pkg::ST_OUT_LD),
                  "result shown without a store read")

endmodule

/* sim/heap_sort_engine_tb.sv */
// Self-checking testbench for heap_sort_engine: drives sets of signed values and checks
// that each set comes back in ascending order with correct last/overflow marks.
// Depends on hse_pkg and the heap_sort_engine RTL.
module heap_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = hse_pkg::DATA_W;
  localparam int CAPACITY    = hse_pkg::MAX_ITEMS_DEFAULT;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 100;

  // Receiver stall patterns
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_CHOPPY,
    SINK_SLOW
  } sink_mode_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  hse_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hse_pkg::out_item_t out_data;

  // Predictor state: values of the open set kept in ascending order
  logic signed [DATA_W-1:0] open_set[$];
  logic                     set_dropped = 1'b0;
  hse_pkg::out_item_t       sorted_expect[$];

  int unsigned mismatches    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;

  heap_sort_engine #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Track one accepted input; a closing transaction releases the whole sorted set
  function automatic void predict_sort(input logic signed [DATA_W-1:0] value, input logic last);
    int                 pos;
    hse_pkg::out_item_t res;
    if (open_set.size() < CAPACITY) begin
      pos = 0;
      while (pos < open_set.size() && open_set[pos] <= value) pos++;
      open_set.insert(pos, value);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (open_set[k]) begin
        res.value_out = open_set[k];
        res.last_out  = (k == open_set.size() - 1);
        res.overflow  = set_dropped;
        sorted_expect.push_back(res);
      end
      open_set.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Mix of full-range, clustered (duplicates) and extreme values
  function automatic logic signed [DATA_W-1:0] random_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      6, 7: v = $signed($urandom_range(0, 15)) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(DATA_W-1){1'b1}}};
          1: v = {1'b1, {(DATA_W-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one transaction; sender idles in bursts with random gaps
  task automatic push_value(input logic signed [DATA_W-1:0] value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 5))
        0: gap = 0;
        1: gap = $urandom_range(15, 40);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= hse_pkg::in_item_t'{value_in: value, last_in: last};
    do @(posedge clk); while (!in_ready);
    predict_sort(value, last);
  endtask

  task automatic send_random_set(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_value(random_value(), i == count - 1);
  endtask

  // Directed sets
  task automatic test_single();
    push_value(-5, 1'b1);
  endtask

  task automatic test_extremes();
    logic signed [DATA_W-1:0] vals[7] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    foreach (vals[i]) push_value(vals[i], i == 6);
  endtask

  task automatic test_equal_values();
    logic signed [DATA_W-1:0] vals[5] = '{7, -3, 7, 7, -3};
    foreach (vals[i]) push_value(vals[i], i == 4);
  endtask

  task automatic test_pairs();
    push_value(2, 1'b0);
    push_value(1, 1'b1);
    push_value(-1, 1'b0);
    push_value(1, 1'b1);
  endtask

  task automatic test_descending();
    for (int i = 0; i < 6; i++) push_value(100 - 40 * i, i == 5);
  endtask

  // Exactly full store: nothing dropped
  task automatic test_full_set();
    send_random_set(CAPACITY);
  endtask

  // Store overflows; the closing transaction is dropped too
  task automatic test_overflow();
    send_random_set(CAPACITY + $urandom_range(1, 4));
  endtask

  // Receiver holds off while two sets are offered, so the input must stall
  task automatic test_backpressure();
    // Let earlier results drain so the hold-off meets a waiting result
    in_valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    hold_requests++;
    send_random_set(8);
    send_random_set(8);
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 12) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      send_random_set(n);
      sent += n;
    end
  endtask

  // Result sink: random stall phases, plus a long hold-off on request
  initial begin : result_sink
    int unsigned holds_done;
    int unsigned phase_left;
    sink_mode_t  mode;
    holds_done = 0;
    phase_left = 0;
    mode       = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = sink_mode_t'($urandom_range(0, 2));
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    hse_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect.size() == 0) begin
        $error("result with none expected: value_out %0d", out_data.value_out);
        mismatches++;
      end else begin
        want = sorted_expect.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_data.value_out);
          mismatches++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
          mismatches++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet == STALL_LIMIT) begin
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : main_seq
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_single();
    test_extremes();
    test_equal_values();
    test_pairs();
    test_descending();
    test_full_set();
    test_overflow();
    test_backpressure();
    test_random_sets();

    in_valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/hse_pkg.sv
hw/rtl/hse_ram.sv
hw/rtl/heap_sort_engine.sv
sim/heap_sort_engine_tb.sv
